@@ rtl/asc_pkg.sv @@
`default_nettype none
package asc_pkg;

	localparam int MAX_CHANNELS_DEF = 16;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_BYTES    = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;

	// Sample format codes.
	localparam logic [1:0] FMT_PCM   = 2'd0;
	localparam logic [1:0] FMT_FLOAT = 2'd1;
	localparam logic [1:0] FMT_ALAW  = 2'd2;
	localparam logic [1:0] FMT_ULAW  = 2'd3;

	localparam logic [1:0] FORMAT_RESET   = FMT_PCM;
	localparam logic [3:0] BYTES_RESET    = 4'd2;
	localparam logic [4:0] CHANNELS_RESET = 5'd1;

	// Float scaling: the product is cut to an integer with these exponent thresholds.
	localparam logic [10:0] F32_EXP_LIMIT = 11'd150;
	localparam logic [10:0] F64_EXP_LIMIT = 11'd1075;

	typedef enum logic [3:0] {
		K_ERR,
		K_U8,
		K_P16,
		K_P24,
		K_P32,
		K_P64,
		K_F32,
		K_F64,
		K_ALAW,
		K_ULAW
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] raw;
		logic [3:0]  chan;
		logic        last;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  chan;
		logic        last;
		logic        neg;
		logic        nan;
		logic [10:0] ex;
		logic [15:0] q;
		logic [68:0] w;
	} work_t;

	function automatic logic [15:0] alaw_decode(input logic [7:0] code);
		logic [7:0]  a;
		logic [15:0] t;
		logic [2:0]  seg;
		a   = code ^ 8'h55;
		seg = a[6:4];
		t   = {8'b0, a[3:0], 4'b0};
		if (seg == 3'd0) begin
			t = t + 16'd8;
		end else begin
			t = (t + 16'h0108) << (seg - 3'd1);
		end
		return a[7] ? t : (16'd0 - t);
	endfunction

	function automatic logic [15:0] ulaw_decode(input logic [7:0] code);
		logic [7:0]  u;
		logic [15:0] t;
		u = ~code;
		t = ({9'b0, u[3:0], 3'b0} + 16'h0084) << u[6:4];
		if (code == 8'h7f) begin
			return 16'hffff;
		end
		return u[7] ? (16'h0084 - t) : (t - 16'h0084);
	endfunction

endpackage
`default_nettype wire

@@ rtl/asc_front.sv @@
`default_nettype none
module asc_front #(
	parameter int MAX_CHANNELS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        sample_format,
	input  wire logic [3:0]        bytes_per_sample,
	input  wire logic [4:0]        channel_count,
	input  wire logic              cfg_clear,
	input  wire logic              take,
	input  wire logic [7:0]        data_byte,
	input  wire logic              stream_start,
	output asc_pkg::entry_t        entry,
	output logic                   push
);
	import asc_pkg::*;

	localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [55:0]   gather_q;
	logic [2:0]    cnt_q;
	logic [PW-1:0] pos_q;

	logic [55:0]   g_base;
	logic [2:0]    c_base;
	logic [8:0]    p_base;
	logic [8:0]    chans;
	logic [3:0]    size;
	logic [63:0]   raw;
	logic          complete;
	logic          last;
	logic          bps_ok;
	logic          pair_ok;
	kind_t         kind;

	always_comb begin
		bps_ok = (bytes_per_sample >= 4'd1) && (bytes_per_sample <= 4'd8);
		size   = bps_ok ? bytes_per_sample : 4'd1;
		if (channel_count == 5'd0) begin
			chans = 9'd1;
		end else if ({4'b0, channel_count} > 9'(MAX_CHANNELS)) begin
			chans = 9'(MAX_CHANNELS);
		end else begin
			chans = {4'b0, channel_count};
		end

		g_base = stream_start ? '0 : gather_q;
		c_base = stream_start ? '0 : cnt_q;
		p_base = stream_start ? '0 : 9'(pos_q);
		if (p_base >= chans) begin
			p_base = '0;
		end

		raw = {8'b0, g_base};
		raw[{c_base, 3'b0} +: 8] = data_byte;
		complete = ({1'b0, c_base} + 4'd1) >= size;
		last     = (p_base + 9'd1) >= chans;

		case (sample_format)
			FMT_PCM:   pair_ok = bytes_per_sample inside {4'd1, 4'd2, 4'd3, 4'd4, 4'd8};
			FMT_FLOAT: pair_ok = bytes_per_sample inside {4'd4, 4'd8};
			default:   pair_ok = (bytes_per_sample == 4'd1);
		endcase

		kind = K_ERR;
		if (bps_ok && pair_ok) begin
			case (sample_format)
				FMT_PCM: begin
					case (bytes_per_sample)
						4'd1:    kind = K_U8;
						4'd2:    kind = K_P16;
						4'd3:    kind = K_P24;
						4'd4:    kind = K_P32;
						default: kind = K_P64;
					endcase
				end
				FMT_FLOAT: kind = (bytes_per_sample == 4'd4) ? K_F32 : K_F64;
				FMT_ALAW:  kind = K_ALAW;
				default:   kind = K_ULAW;
			endcase
		end

		entry.kind = kind;
		entry.raw  = raw;
		entry.chan = p_base[3:0];
		entry.last = last;
		push       = take && complete;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
		end else if (cfg_clear) begin
			gather_q <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
		end else if (take) begin
			if (complete) begin
				gather_q <= '0;
				cnt_q    <= '0;
				pos_q    <= last ? '0 : PW'(p_base + 9'd1);
			end else begin
				gather_q <= raw[55:0];
				cnt_q    <= c_base + 3'd1;
				pos_q    <= PW'(p_base);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/asc_queue.sv @@
`default_nettype none
module asc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire asc_pkg::entry_t wr_entry,
	output logic                 full,
	input  wire logic            pop,
	output logic                 rd_valid,
	output asc_pkg::entry_t      rd_entry
);
	import asc_pkg::*;

	entry_t     mem_q [2];
	logic [1:0] count_q;
	logic       wp_q;
	logic       rp_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_entry = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/asc_back.sv @@
`default_nettype none
module asc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire asc_pkg::entry_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [15:0]          sample,
	output logic [3:0]           channel_index,
	output logic                 frame_end,
	output logic                 format_error
);
	import asc_pkg::*;

	logic  v_s1, v_s2, v_s3;
	work_t w_s1, w_s2;
	work_t n_s1, n_s2;
	logic  adv1, adv2, adv3;

	logic [15:0] res;
	logic [3:0]  chan_s3;
	logic        last_s3;
	logic        err_s3;
	logic [15:0] sample_s3;

	logic [8:0]  d8;
	logic [16:0] dx;
	logic [16:0] v8;
	logic [23:0] m24;
	logic [52:0] m53;
	logic [16:0] q32;
	logic [33:0] prod32;
	logic [15:0] q64;
	logic [65:0] prod64;
	logic        rnd;
	logic [24:0] r24;
	logic [53:0] r53;
	logic [10:0] lim;
	logic [10:0] sh;
	logic [68:0] ip;
	logic        big;

	assign adv3 = !v_s3 || !out_stall;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign pop  = adv1 && in_valid;

	// First stage: magnitudes, mantissa products and the small table formats.
	always_comb begin
		n_s1      = '0;
		n_s1.kind = head.kind;
		n_s1.chan = head.chan;
		n_s1.last = head.last;
		d8  = {1'b0, head.raw[7:0]} - 9'd128;
		dx  = {{8{d8[8]}}, d8};
		v8  = (dx << 8) + (dx << 1);
		m24 = {1'b1, head.raw[22:0]};
		m53 = {1'b1, head.raw[51:0]};
		case (head.kind)
			K_U8:   n_s1.q = (head.raw[7:0] == 8'd0) ? 16'h8000 : v8[15:0];
			K_P16:  n_s1.q = head.raw[15:0];
			K_P24:  n_s1.q = head.raw[23:8];
			K_ALAW: n_s1.q = alaw_decode(head.raw[7:0]);
			K_ULAW: n_s1.q = ulaw_decode(head.raw[7:0]);
			K_P32: begin
				n_s1.neg = head.raw[31];
				n_s1.w   = {37'b0, head.raw[31] ? (~head.raw[31:0] + 32'd1) : head.raw[31:0]};
			end
			K_P64: begin
				n_s1.neg = head.raw[63];
				n_s1.w   = {5'b0, head.raw[63] ? (~head.raw + 64'd1) : head.raw};
			end
			K_F32: begin
				n_s1.neg = head.raw[31];
				n_s1.ex  = {3'b0, head.raw[30:23]};
				n_s1.nan = (&head.raw[30:23]) && (|head.raw[22:0]);
				n_s1.w   = {30'b0, {m24, 15'b0} - {15'b0, m24}};
			end
			K_F64: begin
				n_s1.neg = head.raw[63];
				n_s1.ex  = head.raw[62:52];
				n_s1.nan = (&head.raw[62:52]) && (|head.raw[51:0]);
				n_s1.w   = {1'b0, {m53, 15'b0} - {15'b0, m53}};
			end
			default: n_s1.q = '0;
		endcase
	end

	// Second stage: quotient correction for wide PCM, rounding of the float product
	// back to the source precision.
	always_comb begin
		n_s2   = w_s1;
		q32    = w_s1.w[32:16];
		prod32 = {1'b0, q32, 16'b0} + {16'b0, q32, 1'b0};
		q64    = w_s1.w[63:48];
		prod64 = {2'b0, q64, 48'b0} + {17'b0, q64, 33'b0} + {32'b0, q64, 18'b0}
			+ {47'b0, q64, 3'b0};
		rnd = 1'b0;
		r24 = '0;
		r53 = '0;
		case (w_s1.kind)
			K_P32: begin
				n_s2.q = (prod32 > {1'b0, w_s1.w[32:0]}) ? 16'(q32 - 17'd1) : q32[15:0];
			end
			K_P64: begin
				n_s2.q = (prod64 > {2'b0, w_s1.w[63:0]}) ? (q64 - 16'd1) : q64;
			end
			K_F32: begin
				if (w_s1.w[38]) begin
					rnd    = w_s1.w[14] && ((|w_s1.w[13:0]) || w_s1.w[15]);
					r24    = {1'b0, w_s1.w[38:15]} + {24'b0, rnd};
					n_s2.w = {29'b0, r24, 15'b0};
				end else begin
					rnd    = w_s1.w[13] && ((|w_s1.w[12:0]) || w_s1.w[14]);
					r24    = {1'b0, w_s1.w[37:14]} + {24'b0, rnd};
					n_s2.w = {30'b0, r24, 14'b0};
				end
			end
			K_F64: begin
				if (w_s1.w[67]) begin
					rnd    = w_s1.w[14] && ((|w_s1.w[13:0]) || w_s1.w[15]);
					r53    = {1'b0, w_s1.w[67:15]} + {53'b0, rnd};
					n_s2.w = {r53, 15'b0};
				end else begin
					rnd    = w_s1.w[13] && ((|w_s1.w[12:0]) || w_s1.w[14]);
					r53    = {1'b0, w_s1.w[66:14]} + {53'b0, rnd};
					n_s2.w = {1'b0, r53, 14'b0};
				end
			end
			default: n_s2.q = w_s1.q;
		endcase
	end

	// Third stage: sign, integer cut and saturation.
	always_comb begin
		lim = (w_s2.kind == K_F32) ? F32_EXP_LIMIT : F64_EXP_LIMIT;
		sh  = lim - w_s2.ex;
		ip  = w_s2.w >> sh;
		if (w_s2.neg) begin
			big = (|ip[68:16]) || ip[15];
		end else begin
			big = (|ip[68:16]) || (ip[15:0] >= 16'd32767);
		end
		case (w_s2.kind)
			K_ERR:        res = '0;
			K_P32, K_P64: res = w_s2.neg ? (16'd0 - w_s2.q) : w_s2.q;
			K_F32, K_F64: begin
				if (w_s2.nan || (w_s2.ex == 11'd0)) begin
					res = '0;
				end else if (w_s2.ex >= lim || big) begin
					res = w_s2.neg ? 16'h8000 : 16'h7fff;
				end else begin
					res = w_s2.neg ? (16'd0 - ip[15:0]) : ip[15:0];
				end
			end
			default: res = w_s2.q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			w_s1 <= n_s1;
		end
		if (adv2) begin
			w_s2 <= n_s2;
		end
		if (adv3) begin
			sample_s3 <= res;
			chan_s3   <= w_s2.chan;
			last_s3   <= w_s2.last;
			err_s3    <= (w_s2.kind == K_ERR);
		end
	end

	assign out_valid     = v_s3;
	assign sample        = sample_s3;
	assign channel_index = chan_s3;
	assign frame_end     = last_s3;
	assign format_error  = err_s3;

endmodule
`default_nettype wire

@@ rtl/audio_sample_to_pcm16_converter_unit.sv @@
`default_nettype none
// Converts the bytes of a WAV data chunk, one byte per request, into signed 16-bit
// samples: unsigned 8-bit, 16/24/32/64-bit linear PCM, float32/float64 and G.711
// A-law or mu-law, with the channel index and a frame end mark on each sample. A byte
// is taken every cycle unless in_stall; the byte that completes a sample is written
// into the two-entry queue at once and passes three conversion stages, and one sample
// can leave every cycle unless out_stall. A write to any of the three registers clears
// the partial sample and the channel position, and must only be made while the block
// is idle. Unsupported format and size pairs give a zero sample with format_error set.
module audio_sample_to_pcm16_converter_unit #(
	parameter int MAX_CHANNELS = asc_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               stream_start,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      sample,
	output logic [3:0]              channel_index,
	output logic                    frame_end,
	output logic                    format_error
);
	import asc_pkg::*;

	logic [1:0] format_q;
	logic [3:0] bytes_q;
	logic [4:0] channels_q;
	logic       wr_en;
	logic       cfg_clear;
	logic [1:0] reg_idx;

	entry_t     fe_entry;
	entry_t     head;
	logic       push;
	logic       full;
	logic       head_valid;
	logic       pop;
	logic       take;
	logic [15:0] sample_u;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign wr_en     = psel && penable && pwrite;
	assign cfg_clear = wr_en && (reg_idx == REG_FORMAT || reg_idx == REG_BYTES
		|| reg_idx == REG_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q   <= FORMAT_RESET;
			bytes_q    <= BYTES_RESET;
			channels_q <= CHANNELS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FORMAT:   format_q   <= pwdata[1:0];
				REG_BYTES:    bytes_q    <= pwdata[3:0];
				REG_CHANNELS: channels_q <= pwdata[4:0];
				default:      format_q   <= format_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FORMAT:   prdata = {30'b0, format_q};
			REG_BYTES:    prdata = {28'b0, bytes_q};
			REG_CHANNELS: prdata = {27'b0, channels_q};
			default:      prdata = '0;
		endcase
	end

	// The front side needs a free queue slot for every byte, complete or not.
	assign in_stall = full;
	assign take     = in_valid && !full;

	asc_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_format   (format_q),
		.bytes_per_sample(bytes_q),
		.channel_count   (channels_q),
		.cfg_clear       (cfg_clear),
		.take            (take),
		.data_byte       (data_byte),
		.stream_start    (stream_start),
		.entry           (fe_entry),
		.push            (push)
	);

	asc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(fe_entry),
		.full    (full),
		.pop     (pop),
		.rd_valid(head_valid),
		.rd_entry(head)
	);

	asc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample_u),
		.channel_index(channel_index),
		.frame_end    (frame_end),
		.format_error (format_error)
	);

	assign sample = $signed(sample_u);

endmodule
`default_nettype wire

@@ bench/tb_audio_sample_to_pcm16_converter_unit.sv @@
`default_nettype none
module tb_audio_sample_to_pcm16_converter_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import asc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 62;

	typedef struct {
		logic [15:0] sample;
		logic [3:0]  chan;
		logic        last;
		logic        err;
	} pcm_result_t;

	class pcm16_scoreboard;
		logic [1:0]  fmt;
		logic [3:0]  bps;
		logic [4:0]  chans;
		logic [63:0] gather;
		int          gathered;
		int          position;
		int          mismatches;
		pcm_result_t pending[$];

		function new();
			fmt = FORMAT_RESET;
			bps = BYTES_RESET;
			chans = CHANNELS_RESET;
			gather = '0;
			gathered = 0;
			position = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_FORMAT: fmt = val[1:0];
				REG_BYTES: bps = val[3:0];
				REG_CHANNELS: chans = val[4:0];
				default: return;
			endcase
			gather = '0;
			gathered = 0;
			position = 0;
		endfunction

		function int sat16(longint v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return int'(v);
		endfunction

		// Scales a float of value frac * 2^e2 by 32767, rounds the product to the
		// source precision (to nearest, ties to even) and truncates toward zero.
		function int scaled_float(bit neg, logic [52:0] frac, int e2, int prec);
			logic [68:0] m;
			logic [68:0] keep;
			logic [68:0] rest;
			logic [68:0] half;
			int          top;
			int          cut;
			longint      mag;
			m = {16'b0, frac} * 69'd32767;
			if (m == 0) return 0;
			top = 0;
			for (int i = 0; i < 69; i++) begin
				if (m[i]) top = i;
			end
			cut = top + 1 - prec;
			if (cut > 0) begin
				keep = m >> cut;
				rest = m & ((69'd1 << cut) - 69'd1);
				half = 69'd1 << (cut - 1);
				if (rest > half || (rest == half && keep[0])) keep = keep + 69'd1;
				m = keep << cut;
			end
			if (e2 >= 0) begin
				if (e2 > 20 || (m << e2) >= 69'd32768) mag = 40000;
				else mag = longint'(m << e2);
			end else if (-e2 >= 69) begin
				mag = 0;
			end else begin
				m = m >> (-e2);
				mag = (m >= 69'd40000) ? 40000 : longint'(m);
			end
			return neg ? sat16(-mag) : sat16(mag);
		endfunction

		function int alaw_value(logic [7:0] code);
			logic [7:0] a;
			int         mag;
			a = code ^ 8'h55;
			mag = int'(a[3:0]) << 4;
			if (a[6:4] == 3'd0) mag = mag + 8;
			else mag = (mag + 264) << (int'(a[6:4]) - 1);
			return a[7] ? mag : -mag;
		endfunction

		function int ulaw_value(logic [7:0] code);
			logic [7:0] u;
			int         t;
			u = ~code;
			t = ((int'(u[3:0]) << 3) + 132) << int'(u[6:4]);
			if (code == 8'h7f) return -1;
			return u[7] ? (132 - t) : (t - 132);
		endfunction

		function int convert(logic [63:0] raw);
			longint s;
			case (fmt)
				FMT_PCM: begin
					case (bps)
						4'd1: return sat16((longint'(raw[7:0]) - 128) * 258);
						4'd2: return int'($signed(raw[15:0]));
						4'd3: return int'($signed(raw[23:8]));
						4'd4: return sat16(longint'($signed(raw[31:0])) / 64'sd65538);
						default: begin
							s = $signed(raw);
							return sat16(s / (64'sh7fffffffffffffff / 64'sd32767));
						end
					endcase
				end
				FMT_FLOAT: begin
					if (bps == 4'd4) begin
						if (raw[30:23] == 8'hff) begin
							if (raw[22:0] != 0) return 0;
							return raw[31] ? -32768 : 32767;
						end
						if (raw[30:23] == 0) return scaled_float(raw[31], raw[22:0], -149, 24);
						return scaled_float(raw[31], {1'b1, raw[22:0]},
							int'(raw[30:23]) - 150, 24);
					end
					if (raw[62:52] == 11'h7ff) begin
						if (raw[51:0] != 0) return 0;
						return raw[63] ? -32768 : 32767;
					end
					if (raw[62:52] == 0) return scaled_float(raw[63], raw[51:0], -1074, 53);
					return scaled_float(raw[63], {1'b1, raw[51:0]}, int'(raw[62:52]) - 1075, 53);
				end
				FMT_ALAW: return alaw_value(raw[7:0]);
				default: return ulaw_value(raw[7:0]);
			endcase
		endfunction

		function bit supported();
			case (fmt)
				FMT_PCM: return bps inside {4'd1, 4'd2, 4'd3, 4'd4, 4'd8};
				FMT_FLOAT: return bps inside {4'd4, 4'd8};
				default: return bps == 4'd1;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic start);
			int          size;
			int          nch;
			logic [63:0] raw;
			pcm_result_t r;
			size = (bps >= 1 && bps <= 8) ? int'(bps) : 1;
			nch = (chans == 0) ? 1 : (chans > 16 ? 16 : int'(chans));
			if (start) begin
				gather = '0;
				gathered = 0;
				position = 0;
			end
			if (position >= nch) position = 0;
			raw = gather | (64'(b) << (8 * gathered));
			if (gathered + 1 < size) begin
				gather = raw;
				gathered++;
				return;
			end
			gather = '0;
			gathered = 0;
			r.err = !(bps >= 1 && bps <= 8) || !supported();
			r.sample = r.err ? 16'd0 : 16'(convert(raw));
			r.chan = 4'(position);
			r.last = (position + 1 >= nch);
			position = r.last ? 0 : position + 1;
			pending.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch: %s got %0h expected %0h", what, got, want);
			mismatches++;
		endtask

		task check(pcm_result_t got);
			pcm_result_t want;
			if (pending.size() == 0) begin
				report("unexpected sample", 32'(got.sample), 0);
				return;
			end
			want = pending.pop_front();
			if (got.sample !== want.sample) report("sample", 32'(got.sample), 32'(want.sample));
			if (got.chan !== want.chan) report("channel_index", 32'(got.chan), 32'(want.chan));
			if (got.last !== want.last) report("frame_end", 32'(got.last), 32'(want.last));
			if (got.err !== want.err) report("format_error", 32'(got.err), 32'(want.err));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        stream_start;
	logic        out_valid;
	logic        out_stall;
	logic signed [15:0] sample;
	logic [3:0]  channel_index;
	logic        frame_end;
	logic        format_error;

	pcm16_scoreboard sb;
	bit          quiet;
	bit          sender_idles;
	int          cycles;

	audio_sample_to_pcm16_converter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .stream_start(stream_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample(sample), .channel_index(channel_index),
		.frame_end(frame_end), .format_error(format_error)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		sb = new();
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_valid = 0;
		data_byte = '0;
		stream_start = 0;
		out_stall = 0;
		quiet = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end
	initial cycles = 0;

	// The receiver stalls in bursts, with quiet stretches in between.
	always @(negedge clk) begin
		if (!quiet && arst_n && $urandom_range(0, 9) == 0) begin
			out_stall <= 1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			out_stall <= 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		pcm_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.sample = sample;
			r.chan = channel_index;
			r.last = frame_end;
			r.err = format_error;
			sb.check(r);
		end
	end

	task wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		in_valid <= 0;
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task configure(logic [1:0] f, logic [3:0] b, logic [4:0] c);
		wait_drained();
		write_reg(REG_FORMAT, 32'(f));
		write_reg(REG_BYTES, 32'(b));
		write_reg(REG_CHANNELS, 32'(c));
	endtask

	// Valid stays high from one request to the next unless a gap is inserted.
	task send_byte(logic [7:0] b, logic s);
		@(negedge clk);
		if (sender_idles && !quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		stream_start <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b, s);
	endtask

	task drop_valid();
		@(negedge clk);
		in_valid <= 0;
	endtask

	task send_random(int count, bit pause_midway);
		logic [63:0] raw;
		int          size;
		int          sent;
		size = (sb.bps >= 1 && sb.bps <= 8) ? int'(sb.bps) : 1;
		sent = 0;
		while (sent < count) begin
			raw = {$urandom, $urandom};
			// Floats mostly get exponents that land in the interesting range.
			if (sb.fmt == FMT_FLOAT && $urandom_range(0, 3) != 0) begin
				if (size == 4) raw[30:23] = 8'($urandom_range(110, 143));
				else raw[62:52] = 11'($urandom_range(1006, 1039));
			end
			for (int i = 0; i < size; i++) begin
				send_byte(raw[8*i +: 8], $urandom_range(0, 29) == 0);
				sent++;
				if (pause_midway && sent == count / 2) begin
					drop_valid();
					wait_drained();
				end
			end
		end
		drop_valid();
	endtask

	initial begin
		logic [1:0] f;
		logic [3:0] b;
		logic [4:0] c;
		sender_idles = 1;
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		// Directed: signed 16-bit extremes at reset settings.
		send_byte(8'h00, 0); send_byte(8'h80, 0);
		send_byte(8'hff, 0); send_byte(8'h7f, 0);
		drop_valid();
		configure(FMT_PCM, 4'd1, 5'd3);
		send_byte(8'h00, 0); send_byte(8'hff, 0); send_byte(8'h80, 0); send_byte(8'h7f, 0);
		drop_valid();
		configure(FMT_ULAW, 4'd1, 5'd16);
		send_byte(8'h7f, 0); send_byte(8'hff, 0); send_byte(8'h00, 0);
		drop_valid();
		configure(FMT_ALAW, 4'd1, 5'd0);
		send_byte(8'h55, 0); send_byte(8'hd5, 0); send_byte(8'h00, 0);
		drop_valid();
		// A float NaN must give zero.
		configure(FMT_FLOAT, 4'd4, 5'd2);
		send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'hc0, 0); send_byte(8'h7f, 0);
		drop_valid();
		// A new stream in the middle of a sample drops the partial bytes.
		configure(FMT_PCM, 4'd2, 5'd31);
		send_byte(8'h12, 0); send_byte(8'h34, 1); send_byte(8'h56, 0);
		drop_valid();

		for (int ph = 0; ph < 17; ph++) begin
			case (ph)
				0: begin f = FMT_PCM; b = 4'd1; c = 5'd1; end
				1: begin f = FMT_PCM; b = 4'd2; c = 5'd2; end
				2: begin f = FMT_PCM; b = 4'd3; c = 5'd5; end
				3: begin f = FMT_PCM; b = 4'd4; c = 5'd16; end
				4: begin f = FMT_PCM; b = 4'd8; c = 5'd3; end
				5: begin f = FMT_FLOAT; b = 4'd4; c = 5'd2; end
				6: begin f = FMT_FLOAT; b = 4'd8; c = 5'd4; end
				7: begin f = FMT_ALAW; b = 4'd1; c = 5'd31; end
				8: begin f = FMT_ULAW; b = 4'd1; c = 5'd0; end
				9: begin f = FMT_PCM; b = 4'd5; c = 5'd2; end
				10: begin f = FMT_FLOAT; b = 4'd2; c = 5'd17; end
				11: begin f = FMT_ALAW; b = 4'd0; c = 5'd7; end
				12: begin f = FMT_ULAW; b = 4'd15; c = 5'd1; end
				default: begin
					f = 2'($urandom_range(0, 3));
					b = 4'($urandom_range(0, 15));
					c = 5'($urandom_range(0, 31));
				end
			endcase
			configure(f, b, c);
			if (ph == 16) begin
				quiet = 1;
				sender_idles = 0;
			end
			send_random(PHASE_BYTES, ph == 3);
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
